// ===== sv/dht11_single_wire_reader_macros.svh =====
// Assertion macros used by the checker of the single-wire reader.
`ifndef DHT11_SINGLE_WIRE_READER_MACROS_SVH
`define DHT11_SINGLE_WIRE_READER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHTR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DHTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dhtr_pkg.sv =====
// Types and constants of the single-wire sensor reader.
package dhtr_pkg;

  localparam int unsigned DataBits = 40;
  localparam int unsigned BitIdxW  = 6;
  localparam int unsigned CntW     = 18;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  localparam logic [31:0] LastReadReset = 32'hFFFF_F830;  // minus 2000 ms

  localparam logic [15:0] MinIntervalReset  = 16'd2000;
  localparam logic [17:0] ReleaseReset      = 18'd250000;
  localparam logic [15:0] StartLowReset     = 16'd20000;
  localparam logic [7:0]  SettleReset       = 8'd10;
  localparam logic [7:0]  ResponseLimReset  = 8'd85;
  localparam logic [7:0]  BitLowLimReset    = 8'd55;
  localparam logic [7:0]  BitHighLimReset   = 8'd75;

  typedef enum logic [2:0] {
    PhIdle,
    PhRelease,
    PhStartLow,
    PhSettle,
    PhRespLow,
    PhRespHigh,
    PhBitLow,
    PhBitHigh
  } phase_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTimeout  = 2'd1,
    StChecksum = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinInterval = 3'd0,
    CfgRelease     = 3'd1,
    CfgStartLow    = 3'd2,
    CfgSettle      = 3'd3,
    CfgResponseLim = 3'd4,
    CfgBitLowLim   = 3'd5,
    CfgBitHighLim  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] min_interval_ms;
    logic [17:0] release_before_us;
    logic [15:0] start_low_us;
    logic [7:0]  settle_us;
    logic [7:0]  response_limit;
    logic [7:0]  bit_low_limit;
    logic [7:0]  bit_high_limit;
  } cfg_t;

endpackage

// ===== sv/dhtr_intf.sv =====
// Channel interfaces of the single-wire sensor reader: tick input, result, config write.
interface dhtr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        line_level;
  logic [31:0] now_ms;

  modport source (output valid, cmd, line_level, now_ms, input ready);
  modport sink   (input valid, cmd, line_level, now_ms, output ready);
endinterface

interface dhtr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] humidity_int;
  logic [7:0] humidity_frac;
  logic [7:0] temp_int;
  logic [7:0] temp_frac;
  logic [7:0] checksum_byte;

  modport source (output valid, drive_low, busy_res, done_res, status, humidity_int,
                  humidity_frac, temp_int, temp_frac, checksum_byte, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, status, humidity_int,
                  humidity_frac, temp_int, temp_frac, checksum_byte, output ready);
endinterface

interface dhtr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dhtr_pkg::CfgIdxW-1:0]  index;
  logic [dhtr_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/dhtr_cfg_regs.sv =====
// Configuration register file of the single-wire sensor reader.
module dhtr_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  dhtr_cfg_if.sink       cfg_i,
  output dhtr_pkg::cfg_t cfg_o
);

  dhtr_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid & cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (dhtr_pkg::cfg_idx_e'(cfg_i.index))
        dhtr_pkg::CfgMinInterval: cfg_d.min_interval_ms   = cfg_i.data[15:0];
        dhtr_pkg::CfgRelease:     cfg_d.release_before_us = cfg_i.data[17:0];
        dhtr_pkg::CfgStartLow:    cfg_d.start_low_us      = cfg_i.data[15:0];
        dhtr_pkg::CfgSettle:      cfg_d.settle_us         = cfg_i.data[7:0];
        dhtr_pkg::CfgResponseLim: cfg_d.response_limit    = cfg_i.data[7:0];
        dhtr_pkg::CfgBitLowLim:   cfg_d.bit_low_limit     = cfg_i.data[7:0];
        dhtr_pkg::CfgBitHighLim:  cfg_d.bit_high_limit    = cfg_i.data[7:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_interval_ms   <= dhtr_pkg::MinIntervalReset;
      cfg_q.release_before_us <= dhtr_pkg::ReleaseReset;
      cfg_q.start_low_us      <= dhtr_pkg::StartLowReset;
      cfg_q.settle_us         <= dhtr_pkg::SettleReset;
      cfg_q.response_limit    <= dhtr_pkg::ResponseLimReset;
      cfg_q.bit_low_limit     <= dhtr_pkg::BitLowLimReset;
      cfg_q.bit_high_limit    <= dhtr_pkg::BitHighLimReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/dht11_single_wire_reader.sv =====
// Top level of the single-wire humidity/temperature sensor reader.
//
// Usage: feed one transfer on in_i per microsecond tick, carrying the sampled
// data line (line_level) and the millisecond clock (now_ms). cmd = 1 on an
// idle tick requests a read; while a read runs, cmd is ignored. Every accepted
// tick yields exactly one transfer on out_o: drive_low tells the pad whether to
// pull the line low, busy_res shows a read in progress, and done_res/status mark
// the tick a read ends or a too-early request is answered, with the five bytes alongside.
// Config writes on cfg_i (register index + data) are always ready and are to be
// made only while no read is running and no result is pending.
// Timing: the result of a tick is registered and appears in the cycle after its
// transfer; one tick per cycle is sustained while out_o is taken, set by the single
// state update between the input handshake and the result register.
// Stall: when out_o is not taken, the result register holds and in_i ready
// drops until it drains; no tick is lost or repeated.
// Reset: state goes idle, stored bytes clear, the last-read stamp is set
// 2000 ms in the past, registers return to their defaults, out_o empties.
module dht11_single_wire_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  dhtr_in_if.sink     in_i,
  dhtr_out_if.source  out_o,
  dhtr_cfg_if.sink    cfg_i
);

  dhtr_pkg::cfg_t cfg;

  dhtr_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  dhtr_pkg::phase_e                phase_q, phase_d;
  logic [dhtr_pkg::CntW-1:0]       cnt_q, cnt_d, cnt_inc, wait_lim;
  logic [dhtr_pkg::BitIdxW-1:0]    bit_idx_q, bit_idx_d, bit_idx_inc;
  logic [7:0]                      low_cnt_q, low_cnt_d, samp_lim, sum;
  logic [dhtr_pkg::DataBits-1:0]   data_q, data_d;
  logic [31:0]                     last_ms_q, last_ms_d;
  logic                            fin;
  dhtr_pkg::status_e               fin_st;
  logic                            in_acc;
  logic                            out_valid_q;

  logic       drive_low_d, busy_d, done_d;
  logic [1:0] status_d;
  logic       drive_low_q, busy_q, done_q;
  logic [1:0] status_q;
  logic [dhtr_pkg::DataBits-1:0] bytes_q;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;

  assign cnt_inc     = cnt_q + 1'b1;
  assign bit_idx_inc = bit_idx_q + 1'b1;

  always_comb begin
    case (phase_q)
      dhtr_pkg::PhRelease:  wait_lim = cfg.release_before_us;
      dhtr_pkg::PhStartLow: wait_lim = {2'b00, cfg.start_low_us};
      default:              wait_lim = {10'd0, cfg.settle_us};
    endcase
    case (phase_q)
      dhtr_pkg::PhRespLow,
      dhtr_pkg::PhRespHigh: samp_lim = cfg.response_limit;
      dhtr_pkg::PhBitLow:   samp_lim = cfg.bit_low_limit;
      default:              samp_lim = cfg.bit_high_limit;
    endcase
  end

  // next state
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    bit_idx_d = bit_idx_q;
    low_cnt_d = low_cnt_q;
    data_d    = data_q;
    last_ms_d = last_ms_q;
    fin       = 1'b0;
    fin_st    = dhtr_pkg::StOk;
    sum       = '0;
    case (phase_q)
      dhtr_pkg::PhIdle: begin
        if (in_i.cmd) begin
          if ((in_i.now_ms - last_ms_q) < {16'd0, cfg.min_interval_ms}) begin
            fin = 1'b1;  // too soon: answer with the bytes already held
          end else begin
            last_ms_d = in_i.now_ms;
            data_d    = '0;
            bit_idx_d = '0;
            low_cnt_d = '0;
            cnt_d     = '0;
            phase_d   = dhtr_pkg::PhRelease;
          end
        end
      end
      dhtr_pkg::PhRelease, dhtr_pkg::PhStartLow, dhtr_pkg::PhSettle: begin
        if (cnt_inc >= wait_lim) begin
          cnt_d = '0;
          case (phase_q)
            dhtr_pkg::PhRelease:  phase_d = dhtr_pkg::PhStartLow;
            dhtr_pkg::PhStartLow: phase_d = dhtr_pkg::PhSettle;
            default:              phase_d = dhtr_pkg::PhRespLow;
          endcase
        end else begin
          cnt_d = cnt_inc;
        end
      end
      dhtr_pkg::PhRespLow, dhtr_pkg::PhBitLow: begin
        if (!in_i.line_level) begin
          if (cnt_q > {10'd0, samp_lim}) begin
            fin = 1'b1;
            fin_st = dhtr_pkg::StTimeout;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          if (phase_q == dhtr_pkg::PhBitLow) begin
            low_cnt_d = (cnt_q > 18'd255) ? 8'hFF : cnt_q[7:0];
            phase_d   = dhtr_pkg::PhBitHigh;
          end else begin
            phase_d   = dhtr_pkg::PhRespHigh;
          end
          cnt_d = 18'd1;  // the rising sample opens the high phase
        end
      end
      dhtr_pkg::PhRespHigh, dhtr_pkg::PhBitHigh: begin
        if (in_i.line_level) begin
          if (cnt_q > {10'd0, samp_lim}) begin
            fin = 1'b1;
            fin_st = dhtr_pkg::StTimeout;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          phase_d = dhtr_pkg::PhBitLow;
          cnt_d   = 18'd1;
          if (phase_q == dhtr_pkg::PhBitHigh) begin
            data_d    = {data_q[dhtr_pkg::DataBits-2:0], (cnt_q > {10'd0, low_cnt_q})};
            bit_idx_d = bit_idx_inc;
            if (bit_idx_inc >= dhtr_pkg::BitIdxW'(dhtr_pkg::DataBits)) begin
              sum = data_d[39:32] + data_d[31:24] + data_d[23:16] + data_d[15:8];
              fin = 1'b1;
              fin_st = (sum == data_d[7:0]) ? dhtr_pkg::StOk : dhtr_pkg::StChecksum;
            end
          end
        end
      end
      default: begin
        phase_d = dhtr_pkg::PhIdle;
        cnt_d   = '0;
      end
    endcase
    if (fin) begin
      if (fin_st == dhtr_pkg::StTimeout) data_d = '0;
      phase_d   = dhtr_pkg::PhIdle;
      cnt_d     = '0;
      bit_idx_d = '0;
    end
  end

  // result fields
  always_comb begin
    drive_low_d = (phase_d == dhtr_pkg::PhStartLow);
    busy_d      = (phase_d != dhtr_pkg::PhIdle);
    done_d      = fin;
    status_d    = fin ? fin_st : dhtr_pkg::StOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dhtr_pkg::PhIdle;
      cnt_q       <= '0;
      bit_idx_q   <= '0;
      low_cnt_q   <= '0;
      data_q      <= '0;
      last_ms_q   <= dhtr_pkg::LastReadReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        bit_idx_q   <= bit_idx_d;
        low_cnt_q   <= low_cnt_d;
        data_q      <= data_d;
        last_ms_q   <= last_ms_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      drive_low_q <= drive_low_d;
      busy_q      <= busy_d;
      done_q      <= done_d;
      status_q    <= status_d;
      bytes_q     <= data_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.drive_low     = drive_low_q;
  assign out_o.busy_res      = busy_q;
  assign out_o.done_res      = done_q;
  assign out_o.status        = status_q;
  assign out_o.humidity_int  = bytes_q[39:32];
  assign out_o.humidity_frac = bytes_q[31:24];
  assign out_o.temp_int      = bytes_q[23:16];
  assign out_o.temp_frac     = bytes_q[15:8];
  assign out_o.checksum_byte = bytes_q[7:0];

endmodule

// ===== sv/dhtr_checker.sv =====
// Port-level checker of the single-wire sensor reader, bound to the top level.
`include "dht11_single_wire_reader_macros.svh"

module dhtr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       drive_low_i,
  input logic       busy_res_i,
  input logic       done_res_i,
  input logic [1:0] status_i
);

  // a finished read always leaves the block idle
  `DHTR_ASSERT_NOW(a_done_idle, clk_i, rst_ni, out_valid_i && done_res_i, !busy_res_i,
                   "done while busy")
  // the line is only pulled low inside a read
  `DHTR_ASSERT_NOW(a_drive_busy, clk_i, rst_ni, out_valid_i && drive_low_i, busy_res_i,
                   "drive without busy")
  // a nonzero status only appears with done, and never the unused code
  `DHTR_ASSERT_NOW(a_status_done, clk_i, rst_ni,
                   out_valid_i && (status_i != dhtr_pkg::StOk),
                   done_res_i && (status_i <= dhtr_pkg::StChecksum), "bad status")
  // a stalled result stays put
  `DHTR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(status_i) && $stable(done_res_i),
                    "result dropped under stall")

endmodule

bind dht11_single_wire_reader dhtr_checker u_dhtr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_low_i (out_o.drive_low),
  .busy_res_i  (out_o.busy_res),
  .done_res_i  (out_o.done_res),
  .status_i    (out_o.status)
);
